### src/tkpq_pkg.sv
// ============================================================================
// Two-key priority queue package
// Shared types, sizes and codes for the controller, datapath and top level.
// ============================================================================
package tkpq_pkg;

    // Queue size and derived widths.
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int PAGE_W = 9;
    localparam int PRIO_W = 8;

    // Request types.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_POPPED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // One queue entry; the key fields sit on top so the packed word sorts.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PAGE_W-1:0] pages;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } t_cmd;

endpackage

### src/tkpq_ctrl.sv
// ============================================================================
// Two-key priority queue controller
// Sequences each request through a capture cycle and an update cycle.
// ============================================================================
module tkpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output tkpq_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    logic r_state;
    logic n_state;

    // Next-state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.update  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state == S_UPDATE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/tkpq_datapath.sv
// ============================================================================
// Two-key priority queue datapath
// Sorted shift-register store with per-entry compare and shift.
// ============================================================================
module tkpq_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tkpq_pkg::t_cmd             i_cmd,
    input  logic                       i_req_type,
    input  logic [tkpq_pkg::ID_W-1:0]   i_job_id,
    input  logic [tkpq_pkg::PAGE_W-1:0] i_page_count,
    input  logic [tkpq_pkg::PRIO_W-1:0] i_priority_level,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [tkpq_pkg::ID_W-1:0]   o_out_id,
    output logic [tkpq_pkg::PAGE_W-1:0] o_out_pages,
    output logic [tkpq_pkg::PRIO_W-1:0] o_out_priority,
    output logic [tkpq_pkg::OCC_W-1:0]  o_occupancy
);

    localparam int DEPTH = tkpq_pkg::QUEUE_DEPTH;
    localparam int CW    = tkpq_pkg::CNT_W;
    localparam int KW    = tkpq_pkg::PRIO_W + tkpq_pkg::PAGE_W;

    tkpq_pkg::t_entry r_store [DEPTH];
    tkpq_pkg::t_entry n_store [DEPTH];
    tkpq_pkg::t_entry r_job;
    logic             r_req;
    logic [DEPTH-1:0] r_after;
    logic [DEPTH-1:0] n_after;
    logic [DEPTH-1:0] ins;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             full;
    logic             empty;
    logic [31:0]      occ_wide;
    logic [KW-1:0]    new_key;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign new_key = {i_priority_level, i_page_count};

    // Mark every valid entry that sorts strictly after the incoming job.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_after[k] = (32'(k) < 32'(r_count)) &&
                         ({r_store[k].prio, r_store[k].pages} > new_key);
        end
    end

    // Slots at or past the insertion point, up to the first free slot.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            ins[k] = r_after[k] || (32'(k) == 32'(r_count));
        end
    end

    // Next store contents for insert or pop.
    always_comb begin
        n_count = r_count;
        for (int k = 0; k < DEPTH; k++) begin
            n_store[k] = r_store[k];
        end
        if (r_req == tkpq_pkg::REQ_INSERT) begin
            if (!full) begin
                n_count = r_count + CW'(1);
                for (int k = 0; k < DEPTH; k++) begin
                    if (ins[k]) begin
                        if (k > 0 && ins[(k > 0) ? k - 1 : 0]) begin
                            n_store[k] = r_store[(k > 0) ? k - 1 : 0];
                        end else begin
                            n_store[k] = r_job;
                        end
                    end
                end
            end
        end else begin
            if (!empty) begin
                n_count = r_count - CW'(1);
                for (int k = 0; k < DEPTH - 1; k++) begin
                    n_store[k] = r_store[k + 1];
                end
            end
        end
    end

    assign occ_wide = 32'(n_count);

    // Request capture and compare vector.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req       <= i_req_type;
            r_job.id    <= i_job_id;
            r_job.pages <= i_page_count;
            r_job.prio  <= i_priority_level;
            r_after     <= n_after;
        end
    end

    // Entry store, written on the update cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_store[k] <= n_store[k];
            end
        end
    end

    // Count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.update;
            if (i_cmd.update) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_occupancy    <= occ_wide[tkpq_pkg::OCC_W-1:0];
            o_out_id       <= '0;
            o_out_pages    <= '0;
            o_out_priority <= '0;
            if (r_req == tkpq_pkg::REQ_INSERT) begin
                o_status <= full ? tkpq_pkg::ST_FULL : tkpq_pkg::ST_INSERTED;
            end else if (empty) begin
                o_status <= tkpq_pkg::ST_EMPTY;
            end else begin
                o_status       <= tkpq_pkg::ST_POPPED;
                o_out_id       <= r_store[0].id;
                o_out_pages    <= r_store[0].pages;
                o_out_priority <= r_store[0].prio;
            end
        end
    end

endmodule

### src/two_key_priority_queue.sv
// ============================================================================
// Two-key priority queue
// Bounded job queue sorted by priority level, then page count, then arrival.
// ============================================================================
// A request is taken when start is high and busy is low. In each request,
// the accept edge compares the new job against every stored entry in
// parallel, and the next edge shifts the store and registers the
// result. The result appears for exactly one cycle with o_done high and
// must be taken then, since the receiver cannot stall the block; a new
// request may be started in that same cycle. Every request, including a
// dropped insert or an empty pop, produces exactly one result transfer.
module two_key_priority_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [tkpq_pkg::ID_W-1:0]   i_job_id,
    input  logic [tkpq_pkg::PAGE_W-1:0] i_page_count,
    input  logic [tkpq_pkg::PRIO_W-1:0] i_priority_level,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [tkpq_pkg::ID_W-1:0]   o_out_id,
    output logic [tkpq_pkg::PAGE_W-1:0] o_out_pages,
    output logic [tkpq_pkg::PRIO_W-1:0] o_out_priority,
    output logic [tkpq_pkg::OCC_W-1:0]  o_occupancy
);

    tkpq_pkg::t_cmd cmd;

    // Request sequencing.
    tkpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Sorted store and result registers.
    tkpq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_req_type       (i_req_type),
        .i_job_id         (i_job_id),
        .i_page_count     (i_page_count),
        .i_priority_level (i_priority_level),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_id         (o_out_id),
        .o_out_pages      (o_out_pages),
        .o_out_priority   (o_out_priority),
        .o_occupancy      (o_occupancy)
    );

endmodule
